// ===== hw/rtl/itf_pkg.sv =====
package itf_pkg;

  localparam int LONG_BITS = 32;
  localparam int MAX_WIDTH = 62;

  localparam int VALUE_W    = 64;
  localparam int NUM_DIGITS = 22;
  localparam int DIGIT_W    = 4;
  localparam int DREG_W     = NUM_DIGITS * DIGIT_W;
  localparam int NDIG_W     = $clog2(NUM_DIGITS + 1);
  localparam int STEP_W     = $clog2(VALUE_W);
  localparam int POS_W      = 7;

  localparam logic [VALUE_W-1:0] LONG_MASK =
    (LONG_BITS >= VALUE_W) ? {VALUE_W{1'b1}} :
    ((VALUE_W'(1) << LONG_BITS) - VALUE_W'(1));

  localparam logic [5:0] MAX_WIDTH_V = 6'(MAX_WIDTH);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_UP_A  = 8'h41;

  typedef enum logic [2:0] {
    ACT_SDEC = 3'd0,
    ACT_UDEC = 3'd1,
    ACT_LHEX = 3'd2,
    ACT_UHEX = 3'd3,
    ACT_OCT  = 3'd4,
    ACT_PTR  = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    BASE_DEC,
    BASE_HEX,
    BASE_OCT
  } base_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_NORM,
    ST_SETUP,
    ST_EMIT
  } state_t;

  // Commands from the sequencer to the digit unit.
  typedef struct packed {
    logic  load;
    base_t base;
    logic  step;
    logic  drop;
    logic  shift;
  } itf_dctl_t;

  function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d,
                                            input logic upper);
    logic [7:0] d8;
    d8 = {4'b0, d};
    if (d < 4'd10) begin
      return CH_ZERO + d8;
    end
    return (upper ? CH_UP_A : CH_LO_A) + d8 - 8'd10;
  endfunction

endpackage

// ===== hw/rtl/itf_digit_unit.sv =====
module itf_digit_unit
  import itf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  itf_dctl_t            ctl,
  input  logic [VALUE_W-1:0]   value,
  output logic [DIGIT_W-1:0]   top_digit,
  output logic [NDIG_W-1:0]    ndig
);

  logic [DREG_W-1:0]  dreg_r, dreg_nxt;
  logic [VALUE_W-1:0] bin_r, bin_nxt;
  logic [NDIG_W-1:0]  ndig_r, ndig_nxt;
  logic [DREG_W-1:0]  adj;
  logic [VALUE_W+1:0] oct_src;
  logic [DREG_W-1:0]  oct_load;

  always_comb begin
    oct_src = {2'b00, value};
    for (int i = 0; i < NUM_DIGITS; i++) begin
      oct_load[i*DIGIT_W +: DIGIT_W] = {1'b0, oct_src[i*3 +: 3]};
    end
  end

  // Add three to every BCD digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (dreg_r[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        adj[i*DIGIT_W +: DIGIT_W] = dreg_r[i*DIGIT_W +: DIGIT_W] + 4'd3;
      end else begin
        adj[i*DIGIT_W +: DIGIT_W] = dreg_r[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  always_comb begin
    dreg_nxt = dreg_r;
    bin_nxt  = bin_r;
    ndig_nxt = ndig_r;
    if (ctl.load) begin
      ndig_nxt = NDIG_W'(NUM_DIGITS);
      bin_nxt  = value;
      unique case (ctl.base)
        BASE_HEX: dreg_nxt = DREG_W'(value);
        BASE_OCT: dreg_nxt = oct_load;
        default:  dreg_nxt = '0;
      endcase
    end else if (ctl.step) begin
      dreg_nxt = {adj[DREG_W-2:0], bin_r[VALUE_W-1]};
      bin_nxt  = {bin_r[VALUE_W-2:0], 1'b0};
    end else if (ctl.drop) begin
      dreg_nxt = {dreg_r[DREG_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      ndig_nxt = ndig_r - NDIG_W'(1);
    end else if (ctl.shift) begin
      dreg_nxt = {dreg_r[DREG_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ndig_r <= NDIG_W'(NUM_DIGITS);
    end else begin
      ndig_r <= ndig_nxt;
    end
    dreg_r <= dreg_nxt;
    bin_r  <= bin_nxt;
  end

  assign top_digit = dreg_r[DREG_W-1 -: DIGIT_W];
  assign ndig      = ndig_r;

endmodule

// ===== hw/rtl/integer_to_text_formatter.sv =====
// Channel   Ports                                        Transaction
// input     start, busy, in_value .. in_alternate        start high, busy low
// result    out_strobe, out_char_out, out_last_char      out_strobe high, one cycle
//
// One request passes through a load, the double-dabble steps for decimal only,
// the stripping of leading zero digits (keeping at least one), a setup step and
// then the characters (at most 64); all of it runs on the shared digit register.
// A new request may start as soon as busy falls. Reset is synchronous and
// active low and returns the sequencer to idle. The receiver cannot stall.
module integer_to_text_formatter
  import itf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [63:0]        in_value,
  input  logic [2:0]         in_action,
  input  logic [1:0]         in_length_mods,
  input  logic [5:0]         in_field_width,
  input  logic               in_zero_pad,
  input  logic               in_alternate,
  output logic               out_strobe,
  output logic [7:0]         out_char_out,
  output logic               out_last_char
);

  state_t state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] npre_r, npre_nxt;
  logic [POS_W-1:0] lead_r, lead_nxt;
  logic [POS_W-1:0] total_r, total_nxt;
  logic [5:0] pads_r, pads_nxt;
  logic [5:0] width_r, width_nxt;
  action_t act_r, act_nxt;
  logic neg_r, neg_nxt;
  logic nz_r, nz_nxt;
  logic zpad_r, zpad_nxt;
  logic alt_r, alt_nxt;
  logic strobe_r, strobe_nxt;
  logic [7:0] char_r, char_nxt;
  logic last_r, last_nxt;

  itf_dctl_t dctl;
  logic [DIGIT_W-1:0] top_digit;
  logic [NDIG_W-1:0] ndig;

  action_t act_in;
  logic [VALUE_W-1:0] v_nar, v_mag;
  logic use_long, neg_in;
  logic [5:0] body;
  logic [POS_W-1:0] q;

  always_comb begin
    act_in = (in_action > ACT_PTR) ? ACT_UDEC : action_t'(in_action);
    use_long = (act_in == ACT_PTR) || (in_length_mods < 2'd2);
    v_nar = in_value;
    if (use_long) begin
      v_nar = in_value & LONG_MASK;
      if ((act_in == ACT_SDEC) && in_value[LONG_BITS-1]) begin
        v_nar = v_nar | ~LONG_MASK;
      end
    end
    neg_in = (act_in == ACT_SDEC) && v_nar[VALUE_W-1];
    v_mag = neg_in ? (VALUE_W'(0) - v_nar) : v_nar;
  end

  itf_digit_unit u_digits (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (dctl),
    .value     (v_mag),
    .top_digit (top_digit),
    .ndig      (ndig)
  );

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    pos_nxt    = pos_r;
    npre_nxt   = npre_r;
    lead_nxt   = lead_r;
    total_nxt  = total_r;
    pads_nxt   = pads_r;
    width_nxt  = width_r;
    act_nxt    = act_r;
    neg_nxt    = neg_r;
    nz_nxt     = nz_r;
    zpad_nxt   = zpad_r;
    alt_nxt    = alt_r;
    strobe_nxt = 1'b0;
    char_nxt   = char_r;
    last_nxt   = last_r;
    dctl       = '{load: 1'b0, base: BASE_DEC, step: 1'b0, drop: 1'b0, shift: 1'b0};
    body       = 6'({1'b0, ndig}) + 6'(neg_r);
    q          = pos_r - npre_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          act_nxt   = act_in;
          neg_nxt   = neg_in;
          nz_nxt    = (v_mag != '0);
          zpad_nxt  = in_zero_pad;
          alt_nxt   = in_alternate;
          width_nxt = (in_field_width == 6'd0) ? 6'd1 :
                      (in_field_width > MAX_WIDTH_V) ? MAX_WIDTH_V : in_field_width;
          dctl.load = 1'b1;
          step_nxt  = '0;
          unique case (act_in)
            ACT_LHEX, ACT_UHEX, ACT_PTR: begin
              dctl.base = BASE_HEX;
              state_nxt = ST_NORM;
            end
            ACT_OCT: begin
              dctl.base = BASE_OCT;
              state_nxt = ST_NORM;
            end
            default: begin
              dctl.base = BASE_DEC;
              state_nxt = ST_DABBLE;
            end
          endcase
        end
      end
      ST_DABBLE: begin
        dctl.step = 1'b1;
        step_nxt  = step_r + STEP_W'(1);
        if (step_r == {STEP_W{1'b1}}) begin
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        if ((top_digit == '0) && (ndig > NDIG_W'(1))) begin
          dctl.drop = 1'b1;
        end else begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        unique case (act_r)
          ACT_PTR:            npre_nxt = POS_W'(2);
          ACT_LHEX, ACT_UHEX: npre_nxt = alt_r ? POS_W'(2) : POS_W'(0);
          ACT_OCT:            npre_nxt = (alt_r && nz_r) ? POS_W'(1) : POS_W'(0);
          default:            npre_nxt = POS_W'(0);
        endcase
        pads_nxt  = (width_r > body) ? (width_r - body) : 6'd0;
        lead_nxt  = npre_nxt + POS_W'(pads_nxt) + POS_W'(neg_r);
        total_nxt = lead_nxt + POS_W'(ndig);
        pos_nxt   = '0;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        strobe_nxt = 1'b1;
        priority if (pos_r < npre_r) begin
          char_nxt = (pos_r == '0) ? CH_ZERO : ((act_r == ACT_UHEX) ? CH_UP_X : CH_LO_X);
        end else if (pos_r < lead_r) begin
          if (zpad_r) begin
            char_nxt = (neg_r && (q == '0)) ? CH_MINUS : CH_ZERO;
          end else begin
            char_nxt = (neg_r && (q == POS_W'(pads_r))) ? CH_MINUS : CH_SPACE;
          end
        end else begin
          char_nxt   = digit_char(top_digit, act_r == ACT_UHEX);
          dctl.shift = 1'b1;
        end
        last_nxt = (pos_r == total_r - POS_W'(1));
        pos_nxt  = pos_r + POS_W'(1);
        if (last_nxt) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
      step_r   <= '0;
      pos_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
      step_r   <= step_nxt;
      pos_r    <= pos_nxt;
    end
    npre_r  <= npre_nxt;
    lead_r  <= lead_nxt;
    total_r <= total_nxt;
    pads_r  <= pads_nxt;
    width_r <= width_nxt;
    act_r   <= act_nxt;
    neg_r   <= neg_nxt;
    nz_r    <= nz_nxt;
    zpad_r  <= zpad_nxt;
    alt_r   <= alt_nxt;
    char_r  <= char_nxt;
    last_r  <= last_nxt;
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_strobe    = strobe_r;
  assign out_char_out  = char_r;
  assign out_last_char = last_r;

endmodule
